>>> hw/rtl/csq_pkg.sv
// Shared constants and types for the cursor sequence store.
`timescale 1ns / 1ps
`default_nettype none
package csq_pkg;

  localparam int CAPACITY_SLOTS = 32;
  localparam int IDX_W          = $clog2(CAPACITY_SLOTS);
  localparam int CNT_W          = $clog2(CAPACITY_SLOTS + 1);
  localparam int VAL_W          = 64;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_ADVANCE = 3'd1;
  localparam logic [2:0] OP_INSERT  = 3'd2;
  localparam logic [2:0] OP_ATTACH  = 3'd3;
  localparam logic [2:0] OP_REMOVE  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOCUR = 2'd2;

  typedef struct packed {
    logic [2:0]       op;
    logic [VAL_W-1:0] entry_value;
  } csq_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] current_value;
    logic             has_current;
    logic [5:0]       entry_count;
    logic [1:0]       status;
  } csq_out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } csq_mem_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/csq_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module csq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/csq_ctrl.sv
// Request decode and shift sequencer driving the slot memory.
`timescale 1ns / 1ps
`default_nettype none
module csq_ctrl
  import csq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire csq_in_t      in_data,
  output logic              res_valid,
  input  wire logic         res_ready,
  output csq_out_t          res_data,
  output csq_mem_req_t      mem_req,
  input  wire logic [VAL_W-1:0] mem_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_DATA  = 3'd4;

  logic [2:0]       state_r,   state_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [CNT_W-1:0] cursor_r,  cursor_nxt;
  logic [CNT_W-1:0] rem_r,     rem_nxt;
  logic             wr_pend_r, wr_pend_nxt;
  logic [VAL_W-1:0] val_r,     val_nxt;
  logic [IDX_W-1:0] pos_r,     pos_nxt;
  logic [IDX_W-1:0] rd_idx_r,  rd_idx_nxt;
  logic [IDX_W-1:0] wr_addr_r, wr_addr_nxt;
  logic             up_r,      up_nxt;
  logic [1:0]       status_r,  status_nxt;

  logic             cur;
  logic             full;
  logic [CNT_W-1:0] pos_c;
  logic [CNT_W-1:0] ins_n;
  logic [CNT_W-1:0] rem_n;

  assign cur   = cursor_r < count_r;
  assign full  = count_r == CNT_W'(CAPACITY_SLOTS);
  assign pos_c = (in_data.op == OP_INSERT) ? (cur ? cursor_r : '0)
                                           : (cur ? cursor_r + 1'b1 : count_r);
  assign ins_n = count_r - pos_c;
  assign rem_n = count_r - cursor_r - 1'b1;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cursor_nxt  = cursor_r;
    rem_nxt     = rem_r;
    wr_pend_nxt = wr_pend_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    rd_idx_nxt  = rd_idx_r;
    wr_addr_nxt = wr_addr_r;
    up_nxt      = up_r;
    status_nxt  = status_r;
    mem_req     = '0;
    in_ready    = state_r == S_IDLE;
    res_valid   = 1'b0;
    res_data.current_value = cur ? mem_rdata : '0;
    res_data.has_current   = cur;
    res_data.entry_count   = 6'(count_r);
    res_data.status        = status_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt  = ST_DONE;
          val_nxt     = in_data.entry_value;
          wr_pend_nxt = 1'b0;
          state_nxt   = S_RD;
          case (in_data.op)
            OP_START: begin
              cursor_nxt = '0;
            end
            OP_ADVANCE: begin
              if (cur) begin
                cursor_nxt = cursor_r + 1'b1;
              end else begin
                status_nxt = ST_NOCUR;
              end
            end
            OP_INSERT, OP_ATTACH: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                pos_nxt    = pos_c[IDX_W-1:0];
                cursor_nxt = pos_c;
                count_nxt  = count_r + 1'b1;
                rem_nxt    = ins_n;
                rd_idx_nxt = IDX_W'(count_r - 1'b1);
                up_nxt     = 1'b0;
                state_nxt  = (ins_n != '0) ? S_SHIFT : S_PUT;
              end
            end
            OP_REMOVE: begin
              if (cur) begin
                count_nxt  = count_r - 1'b1;
                rem_nxt    = rem_n;
                rd_idx_nxt = IDX_W'(cursor_r + 1'b1);
                up_nxt     = 1'b1;
                state_nxt  = (rem_n != '0) ? S_SHIFT : S_RD;
              end else begin
                status_nxt = ST_NOCUR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // one entry per cycle: read slot k, write it one place over next cycle
      S_SHIFT: begin
        if (wr_pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_addr_r;
          mem_req.wdata = mem_rdata;
        end
        if (rem_r != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_idx_r;
          wr_pend_nxt   = 1'b1;
          wr_addr_nxt   = up_r ? rd_idx_r - 1'b1 : rd_idx_r + 1'b1;
          rd_idx_nxt    = up_r ? rd_idx_r + 1'b1 : rd_idx_r - 1'b1;
          rem_nxt       = rem_r - 1'b1;
        end else begin
          wr_pend_nxt = 1'b0;
          state_nxt   = up_r ? S_RD : S_PUT;
        end
      end

      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = val_r;
        state_nxt     = S_RD;
      end

      // the read comes in the cycle after the last write, so no bypass is needed
      S_RD: begin
        if (cur) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cursor_r[IDX_W-1:0];
        end
        state_nxt = S_DATA;
      end

      S_DATA: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cursor_r  <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cursor_r  <= cursor_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    rd_idx_r  <= rd_idx_nxt;
    wr_addr_r <= wr_addr_nxt;
    up_r      <= up_nxt;
    status_r  <= status_nxt;
  end

endmodule
`default_nettype wire

>>> hw/rtl/cursor_sequence_store_top.sv
// Top level of the cursor sequence store: sequencer, slot memory, output register.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   csq_in_t  (op, entry_value)
//   out_     output     out_valid / out_ready csq_out_t (current_value, has_current,
//                                             entry_count, status)
//
// Start, advance, rejected and unused requests go from idle through the read and
// result states. Insert and attach add the shift loop and the put state before
// the read, remove the shift loop only; the loop moves n entries (at most
// CAPACITY_SLOTS - 1), one entry per cycle through the slot memory's write and
// read ports, and is skipped when n is zero. One request is worked at a time; a
// new one is taken while the previous result waits in the output register.
// Reset clears count and cursor; slot contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module cursor_sequence_store_top
  import csq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire csq_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output csq_out_t     out_data
);

  csq_mem_req_t     mem_req;
  logic [VAL_W-1:0] mem_rdata;
  logic             res_valid;
  logic             res_ready;
  csq_out_t         res_data;

  logic     out_valid_r, out_valid_nxt;
  csq_out_t out_r;

  csq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  csq_ram #(
    .DEPTH (CAPACITY_SLOTS),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> sim/cursor_sequence_store_checker.sv
// Checker for the cursor sequence store: predicts every result and compares it on arrival.
`timescale 1ns / 1ps
module cursor_sequence_store_checker
  import csq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  csq_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  csq_out_t out_data,
  output int       fail_count,
  output int       pending,
  output int       results_checked
);

  logic [VAL_W-1:0] slot_words [CAPACITY_SLOTS];
  int               held_count;
  int               cursor_pos;
  int               fails;
  int               checked;
  csq_out_t         due_results [$];

  // Applies one request to the shadow store and returns the result it should give.
  function automatic csq_out_t apply_request(input csq_in_t req);
    csq_out_t   res;
    logic [1:0] st;
    bit         cur;
    int         pos;
    int         i;
    st  = ST_DONE;
    cur = cursor_pos < held_count;
    case (req.op)
      OP_START: cursor_pos = 0;
      OP_ADVANCE: begin
        if (cur) cursor_pos++;
        else st = ST_NOCUR;
      end
      OP_INSERT, OP_ATTACH: begin
        if (held_count >= CAPACITY_SLOTS) begin
          st = ST_FULL;
        end else begin
          if (req.op == OP_INSERT) pos = cur ? cursor_pos : 0;
          else pos = cur ? cursor_pos + 1 : held_count;
          for (i = held_count; i > pos; i--) slot_words[i] = slot_words[i-1];
          slot_words[pos] = req.entry_value;
          held_count++;
          cursor_pos = pos;
        end
      end
      OP_REMOVE: begin
        if (cur) begin
          for (i = cursor_pos; i + 1 < held_count; i++) slot_words[i] = slot_words[i+1];
          held_count--;
        end else begin
          st = ST_NOCUR;
        end
      end
      default: ;
    endcase
    cur = cursor_pos < held_count;
    res.current_value = cur ? slot_words[cursor_pos] : '0;
    res.has_current   = cur;
    res.entry_count   = held_count[5:0];
    res.status        = st;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    csq_out_t want;
    if (!rst_n) begin
      held_count = 0;
      cursor_pos = 0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result 0x%0h with no request outstanding", out_data);
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("current_value", want.current_value, out_data.current_value);
          check_field("has_current", 64'(want.has_current), 64'(out_data.has_current));
          check_field("entry_count", 64'(want.entry_count), 64'(out_data.entry_count));
          check_field("status", 64'(want.status), 64'(out_data.status));
          checked++;
        end
      end
      if (in_valid && in_ready) due_results.push_back(apply_request(in_data));
    end
    fail_count      <= fails;
    pending         <= due_results.size();
    results_checked <= checked;
  end

endmodule

>>> sim/cursor_sequence_store_top_tb.sv
// Testbench top for the cursor sequence store: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module cursor_sequence_store_top_tb;
  import csq_pkg::*;

  localparam int         LIMIT_CYCLES = 500000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         RANDOM_REQS  = 620;
  localparam logic [2:0] OP_SPARE_5   = 3'd5;
  localparam logic [2:0] OP_SPARE_6   = 3'd6;
  localparam logic [2:0] OP_SPARE_7   = 3'd7;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  csq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  csq_out_t out_data;

  int check_fails;
  int pending;
  int results_checked;
  int sent;
  int cycle_cnt;
  bit idle_on = 1'b1;

  always #5 clk = ~clk;

  cursor_sequence_store_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  cursor_sequence_store_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (check_fails),
    .pending        (pending),
    .results_checked(results_checked)
  );

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Grow phases favour insert and attach so the store reaches capacity; shrink
  // phases favour remove so it empties again.
  function automatic logic [2:0] pick_op(input bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 97) return 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
    if (grow) begin
      if (r < 8)  return OP_START;
      if (r < 18) return OP_ADVANCE;
      if (r < 50) return OP_INSERT;
      if (r < 85) return OP_ATTACH;
    end else begin
      if (r < 14) return OP_START;
      if (r < 35) return OP_ADVANCE;
      if (r < 42) return OP_INSERT;
      if (r < 50) return OP_ATTACH;
    end
    return OP_REMOVE;
  endfunction

  task automatic offer_request(input logic [2:0] op, input logic [63:0] word);
    csq_in_t req;
    req.op          = op;
    req.entry_value = word;
    if (idle_on && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random stalls, one long hold-off so the block backs up, and a
  // stretch with no stalls at all.
  initial begin
    int  taken;
    int  hold;
    bit  hold_done;
    taken     = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (!hold_done && taken >= 150) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
      end else if (taken >= 400 && taken < 550) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 26);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timed out after %0d cycles with %0d results outstanding", cycle_cnt, pending);
    $display("cursor_sequence_store_top_tb failed");
    $finish;
  end

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty store: remove and advance both rejected, then placements starting from an empty store
    offer_request(OP_REMOVE, '0);
    offer_request(OP_ADVANCE, '1);
    offer_request(OP_START, '0);
    offer_request(OP_ATTACH, '1);
    offer_request(OP_INSERT, '0);
    offer_request(OP_ATTACH, 64'h5555_5555_5555_5555);
    offer_request(OP_ADVANCE, '0);
    offer_request(OP_ADVANCE, '0);
    offer_request(OP_ADVANCE, '0);
    // no current item: attach appends, insert goes to the front
    offer_request(OP_ATTACH, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_request(OP_ADVANCE, '0);
    offer_request(OP_INSERT, 64'h8000_0000_0000_0001);
    offer_request(OP_SPARE_5, '1);
    offer_request(OP_SPARE_6, rand_word());
    offer_request(OP_SPARE_7, '1);
    offer_request(OP_START, '0);
    offer_request(OP_REMOVE, '0);
    offer_request(OP_ADVANCE, '0);
    offer_request(OP_ADVANCE, '0);
    offer_request(OP_ADVANCE, '0);
    // removing the last entry leaves the cursor past the end
    offer_request(OP_REMOVE, '0);
    offer_request(OP_REMOVE, '0);

    // fill to capacity, hit the full rejections, then drain completely
    offer_request(OP_START, '0);
    for (n = 0; n < CAPACITY_SLOTS; n++)
      offer_request(n[0] ? OP_INSERT : OP_ATTACH, rand_word());
    offer_request(OP_INSERT, '1);
    offer_request(OP_ATTACH, '1);
    offer_request(OP_START, '0);
    for (n = 0; n < CAPACITY_SLOTS + 2; n++) offer_request(OP_REMOVE, '0);

    for (n = 0; n < RANDOM_REQS; n++) begin
      idle_on = !(n >= 300 && n < 450);
      if (n == 350) wait_all_results();
      offer_request(pick_op((n % 130) < 50), rand_word());
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests sent, %0d results checked: all operations and spare codes,",
             sent, results_checked);
    $display("full and no-current rejections, fill to capacity and drain, stalls both sides");
    if (check_fails == 0) begin
      $display("cursor_sequence_store_top_tb passed");
    end else begin
      $display("cursor_sequence_store_top_tb failed");
    end
    $finish;
  end

endmodule
